>>> hdl/rtyc_pkg.sv
// Shared types, constants and register codes for the RGB to YCbCr 4:2:0 block.
// No dependencies; every other file of the block but rtyc_stream_if imports this package.
`default_nettype none

package rtyc_pkg;

   localparam int MAX_WIDTH_DEFAULT  = 2048;
   localparam int MAX_HEIGHT_DEFAULT = 2048;

   // configuration port
   localparam int CFG_W      = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

   // register select, taken from paddr[2]
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // color conversion, Q16 coefficients
   localparam int PROD_W = 24;
   localparam logic [15:0] Y_COEF_B    = 16'd6391;
   localparam logic [15:0] Y_COEF_G    = 16'd32909;
   localparam logic [15:0] Y_COEF_R    = 16'd16763;
   localparam logic [15:0] C_COEF_MAIN = 16'd28672;
   localparam logic [15:0] CB_COEF_G   = 16'd18996;
   localparam logic [15:0] CB_COEF_R   = 16'd9676;
   localparam logic [15:0] CR_COEF_G   = 16'd24009;
   localparam logic [15:0] CR_COEF_B   = 16'd4662;
   localparam logic [7:0]  LUMA_OFFSET   = 8'd16;
   localparam logic [7:0]  CHROMA_OFFSET = 8'd128;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_rgb_type;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] cb;
      logic [7:0] cr;
   } pixel_ycc_type;

   // position of a pixel inside the frame, carried down the pipe
   typedef struct packed {
      logic row_odd;
      logic col_odd;
      logic frame_last;
   } pos_flags_type;

   typedef struct packed {
      logic [7:0] luma_top_left;
      logic [7:0] luma_top_right;
      logic [7:0] luma_bottom_left;
      logic [7:0] luma_bottom_right;
      logic [7:0] blue_chroma_avg;
      logic [7:0] red_chroma_avg;
      logic       frame_last;
   } block_type;

endpackage

`default_nettype wire

>>> hdl/rtyc_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Used for the pixel request channel and the block result channel.
`default_nettype none

interface rtyc_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/rgb_to_ycbcr_420_downsampler_top.sv
// Top level of the RGB to YCbCr 4:2:0 downsampler: raster counters and wiring.
// Depends on rtyc_pkg, rtyc_stream_if, rtyc_csr, rtyc_convert, rtyc_line_buffer.
//
//   channel    dir  handshake            payload
//   req_chan   in   valid/ready          red, green, blue (one pixel)
//   rsp_chan   out  valid/ready          four lumas, two chroma averages, frame_last
//   csr        in   psel/penable/pready  image_width (0x0), image_height (0x4)
//
// One pixel per clock sustained while results are taken; after its last pixel a
// result passes the product stage, the sum stage, the line store read and the
// output register. Reset is synchronous; the line store is not cleared.
// A stalled result only holds the pipe once every stage in front is occupied.
`default_nettype none

module rgb_to_ycbcr_420_downsampler_top #(
   parameter int MAX_WIDTH  = rtyc_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = rtyc_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   rtyc_stream_if.sink                     req_chan,
   rtyc_stream_if.source                   rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [rtyc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rtyc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rtyc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import rtyc_pkg::*;

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int RC     = $clog2(MAX_HEIGHT);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int PAIRS  = (MAX_WIDTH + 1) / 2;
   localparam int ADDR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;

   logic [CW-1:0]     col_ff, col_in;
   logic [RC-1:0]     row_ff, row_in;
   logic [WW-1:0]     width_eff, col_inc, last_col;
   logic [HW-1:0]     height_eff, row_inc, last_row;
   logic              accept;
   pos_flags_type     in_flags;
   logic [ADDR_W-1:0] in_addr;

   logic              conv_valid, conv_ready;
   logic              lb_ready;
   pixel_ycc_type     conv_pixel;
   pos_flags_type     conv_flags;
   logic [ADDR_W-1:0] conv_addr;
   block_type         block;

   rtyc_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .width_eff  (width_eff),
      .height_eff (height_eff)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign col_inc  = WW'(col_ff) + WW'(1);
   assign row_inc  = HW'(row_ff) + HW'(1);
   assign last_col = (width_eff & ~WW'(1)) - WW'(1);
   assign last_row = (height_eff & ~HW'(1)) - HW'(1);

   // counters also wrap when already past the bound after a size change
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_inc >= width_eff) begin
            col_in = '0;
            row_in = (row_inc >= height_eff) ? '0 : RC'(row_inc);
         end else begin
            col_in = CW'(col_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_comb begin
      in_flags.row_odd    = row_ff[0];
      in_flags.col_odd    = col_ff[0];
      in_flags.frame_last = (WW'(col_ff) == last_col) && (HW'(row_ff) == last_row);
      in_addr             = ADDR_W'(col_ff >> 1);
   end

   assign req_chan.ready = conv_ready;

   rtyc_convert #(
      .ADDR_W (ADDR_W)
   ) u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (conv_ready),
      .in_pixel  (req_chan.payload),
      .in_flags  (in_flags),
      .in_addr   (in_addr),
      .out_valid (conv_valid),
      .out_ready (lb_ready),
      .out_pixel (conv_pixel),
      .out_flags (conv_flags),
      .out_addr  (conv_addr)
   );

   rtyc_line_buffer #(
      .DEPTH (PAIRS)
   ) u_line_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (conv_valid),
      .in_ready  (lb_ready),
      .in_pixel  (conv_pixel),
      .in_flags  (conv_flags),
      .in_addr   (conv_addr),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_block (block)
   );

   assign rsp_chan.payload = block;

endmodule

`default_nettype wire

>>> hdl/rtyc_csr.sv
// Configuration registers (image width and height) behind an APB-style port.
// Depends on rtyc_pkg; gives out the dimensions clamped to their legal range.
`default_nettype none

module rtyc_csr #(
   parameter int MAX_WIDTH  = rtyc_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = rtyc_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rtyc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rtyc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rtyc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output logic [$clog2(MAX_WIDTH+1)-1:0]    width_eff,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]   height_eff
);
   import rtyc_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int WE = (WW > CFG_W) ? WW : CFG_W;
   localparam int HE = (HW > CFG_W) ? HW : CFG_W;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             wr_en;
   logic             reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[CSR_ADDR_W-1];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_IMAGE_WIDTH:  width_in  = pwdata[CFG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      if (width_ff < CFG_W'(2)) begin
         width_eff = WW'(2);
      end else if (WE'(width_ff) > WE'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(width_ff);
      end
   end

   always_comb begin
      if (height_ff < CFG_W'(2)) begin
         height_eff = HW'(2);
      end else if (HE'(height_ff) > HE'(MAX_HEIGHT)) begin
         height_eff = HW'(MAX_HEIGHT);
      end else begin
         height_eff = HW'(height_ff);
      end
   end

endmodule

`default_nettype wire

>>> hdl/rtyc_convert.sv
// Two-stage RGB to YCbCr converter: constant products, then sums and offsets.
// Depends on rtyc_pkg; position flags and line address ride along each pixel.
`default_nettype none

module rtyc_convert #(
   parameter int ADDR_W = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rtyc_pkg::pixel_rgb_type in_pixel,
   input  rtyc_pkg::pos_flags_type in_flags,
   input  logic [ADDR_W-1:0]       in_addr,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rtyc_pkg::pixel_ycc_type out_pixel,
   output rtyc_pkg::pos_flags_type out_flags,
   output logic [ADDR_W-1:0]       out_addr
);
   import rtyc_pkg::*;

   typedef struct packed {
      logic [PROD_W-1:0] yb;
      logic [PROD_W-1:0] yg;
      logic [PROD_W-1:0] yr;
      logic [PROD_W-1:0] cbb;
      logic [PROD_W-1:0] cbg;
      logic [PROD_W-1:0] cbr;
      logic [PROD_W-1:0] crr;
      logic [PROD_W-1:0] crg;
      logic [PROD_W-1:0] crb;
   } prod_type;

   prod_type          prod_ff, prod_in;
   pos_flags_type     flags_a_ff, flags_b_ff;
   logic [ADDR_W-1:0] addr_a_ff, addr_b_ff;
   logic              va_ff, vb_ff;
   pixel_ycc_type     ycc_ff, ycc_in;
   logic [PROD_W-1:0] y_sum, cb_sum, cr_sum;
   logic              ready_b, load_a, load_b;

   assign ready_b  = !vb_ff || out_ready;
   assign in_ready = !va_ff || ready_b;
   assign load_a   = in_valid && in_ready;
   assign load_b   = va_ff && ready_b;

   always_comb begin
      prod_in.yb  = PROD_W'(in_pixel.blue)  * PROD_W'(Y_COEF_B);
      prod_in.yg  = PROD_W'(in_pixel.green) * PROD_W'(Y_COEF_G);
      prod_in.yr  = PROD_W'(in_pixel.red)   * PROD_W'(Y_COEF_R);
      prod_in.cbb = PROD_W'(in_pixel.blue)  * PROD_W'(C_COEF_MAIN);
      prod_in.cbg = PROD_W'(in_pixel.green) * PROD_W'(CB_COEF_G);
      prod_in.cbr = PROD_W'(in_pixel.red)   * PROD_W'(CB_COEF_R);
      prod_in.crr = PROD_W'(in_pixel.red)   * PROD_W'(C_COEF_MAIN);
      prod_in.crg = PROD_W'(in_pixel.green) * PROD_W'(CR_COEF_G);
      prod_in.crb = PROD_W'(in_pixel.blue)  * PROD_W'(CR_COEF_B);
   end

   // Chroma sums wrap modulo 2^24; bits 23:16 are still the floored
   // quotient by 65536, two's complement, which is all that is kept.
   always_comb begin
      y_sum  = prod_ff.yb + prod_ff.yg + prod_ff.yr;
      cb_sum = prod_ff.cbb - prod_ff.cbg - prod_ff.cbr;
      cr_sum = prod_ff.crr - prod_ff.crg - prod_ff.crb;
      ycc_in.y  = y_sum[PROD_W-1 -: 8]  + LUMA_OFFSET;
      ycc_in.cb = cb_sum[PROD_W-1 -: 8] + CHROMA_OFFSET;
      ycc_in.cr = cr_sum[PROD_W-1 -: 8] + CHROMA_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (in_ready) va_ff <= in_valid;
         if (ready_b)  vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         prod_ff    <= prod_in;
         flags_a_ff <= in_flags;
         addr_a_ff  <= in_addr;
      end
      if (load_b) begin
         ycc_ff     <= ycc_in;
         flags_b_ff <= flags_a_ff;
         addr_b_ff  <= addr_a_ff;
      end
   end

   assign out_valid = vb_ff;
   assign out_pixel = ycc_ff;
   assign out_flags = flags_b_ff;
   assign out_addr  = addr_b_ff;

endmodule

`default_nettype wire

>>> hdl/rtyc_line_buffer.sv
// Line store and 2x2 block assembly with the result output register.
// Depends on rtyc_pkg. Two banks hold even and odd columns of the even row.
`default_nettype none

module rtyc_line_buffer #(
   parameter int  DEPTH  = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rtyc_pkg::pixel_ycc_type in_pixel,
   input  rtyc_pkg::pos_flags_type in_flags,
   input  logic [ADDR_W-1:0]       in_addr,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rtyc_pkg::block_type     out_block
);
   import rtyc_pkg::*;

   pixel_ycc_type mem_even [DEPTH];
   pixel_ycc_type mem_odd  [DEPTH];

   pixel_ycc_type rd_even_ff, rd_odd_ff;
   pixel_ycc_type pixel_ff;
   pixel_ycc_type left_ff;
   pos_flags_type flags_ff;
   logic          v_ff;
   block_type     block_ff, block_in;
   logic          out_v_ff;
   logic          is_block, out_free, leave, load;
   logic          wr_en, rd_en;
   logic [9:0]    cb_sum, cr_sum;

   assign is_block = flags_ff.row_odd & flags_ff.col_odd;
   assign out_free = !out_v_ff || out_ready;
   assign leave    = v_ff && (!is_block || out_free);
   assign in_ready = !v_ff || leave;
   assign load     = in_valid && in_ready;

   // Writes and reads sit in the same stage and pixels pass in order, so the
   // upper row is always complete before the lower row looks it up.
   assign wr_en = load && !in_flags.row_odd;
   assign rd_en = load && in_flags.row_odd;

   always_ff @(posedge clock) begin
      if (wr_en && !in_flags.col_odd) mem_even[in_addr] <= in_pixel;
      if (rd_en) rd_even_ff <= mem_even[in_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && in_flags.col_odd) mem_odd[in_addr] <= in_pixel;
      if (rd_en) rd_odd_ff <= mem_odd[in_addr];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= in_pixel;
         flags_ff <= in_flags;
      end
   end

   always_comb begin
      cb_sum = 10'(rd_even_ff.cb) + 10'(rd_odd_ff.cb) + 10'(left_ff.cb) + 10'(pixel_ff.cb);
      cr_sum = 10'(rd_even_ff.cr) + 10'(rd_odd_ff.cr) + 10'(left_ff.cr) + 10'(pixel_ff.cr);
      block_in.luma_top_left     = rd_even_ff.y;
      block_in.luma_top_right    = rd_odd_ff.y;
      block_in.luma_bottom_left  = left_ff.y;
      block_in.luma_bottom_right = pixel_ff.y;
      block_in.blue_chroma_avg   = cb_sum[9:2];
      block_in.red_chroma_avg    = cr_sum[9:2];
      block_in.frame_last        = flags_ff.frame_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= 1'b0;
         out_v_ff <= 1'b0;
         left_ff  <= '0;
      end else begin
         if (in_ready) v_ff <= in_valid;
         if (leave && is_block) begin
            out_v_ff <= 1'b1;
         end else if (out_ready) begin
            out_v_ff <= 1'b0;
         end
         // even column of the lower row waits here for its right neighbor
         if (leave && flags_ff.row_odd && !flags_ff.col_odd) left_ff <= pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (leave && is_block) block_ff <= block_in;
   end

   assign out_valid = out_v_ff;
   assign out_block = block_ff;

endmodule

`default_nettype wire
